### rtl/core/wwpf_pkg.sv
// Shared types and constants for the wrapped-window peak finder.
`timescale 1ns / 1ps
package wwpf_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PAD_WIDTH  = 2'd0,
    CFG_PAD_HEIGHT = 2'd1,
    CFG_RADIUS     = 2'd2,
    CFG_SCALE      = 2'd3
  } cfg_idx_e;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int DIM_CFG_W   = 11;
  localparam int RADIUS_W    = 10;
  localparam int LIM_W       = 2 * RADIUS_W;
  localparam int SCALE_W     = 17;

  localparam logic [DIM_CFG_W-1:0] PAD_DIM_RST = 11'd1024;
  localparam logic [RADIUS_W-1:0]  RADIUS_RST  = 10'd20;
  localparam logic [SCALE_W-1:0]   SCALE_RST   = 17'd16384;

  localparam int MAX_DIM_DEF     = 1024;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam int SAMPLE_W = 32;
  // sample after extension; one spare bit keeps wide SAMPLE_BITS values positive
  localparam int VALUE_W  = SAMPLE_W + 1;

  localparam int OFFSET_W    = 10;
  localparam int SHIFT_W     = 26;
  localparam int PEAK_W      = 32;
  localparam int XS_LSB      = 2 * OFFSET_W;
  localparam int YS_LSB      = XS_LSB + SHIFT_W;
  localparam int PK_LSB      = YS_LSB + SHIFT_W;
  localparam int OUT_DATA_W  = PK_LSB + PEAK_W;
  localparam int SHIFT_LIMIT = 33488896;

  // handshake between two stages
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

### rtl/core/wwpf_cfg_regs.sv
// Configuration registers, holding clamped raster size, squared radius and scale.
`timescale 1ns / 1ps
module wwpf_cfg_regs #(
  parameter int MAX_DIM = wwpf_pkg::MAX_DIM_DEF,
  parameter int DIM_W   = $clog2(MAX_DIM + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wwpf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [wwpf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output logic [DIM_W-1:0]                 width_o,
  output logic [DIM_W-1:0]                 height_o,
  output logic [wwpf_pkg::LIM_W-1:0]       lim_o,
  output logic [wwpf_pkg::SCALE_W-1:0]     scale_o
);
  import wwpf_pkg::*;

  logic [DIM_W-1:0]   width_q, height_q;
  logic [LIM_W-1:0]   lim_q;
  logic [SCALE_W-1:0] scale_q;
  logic [RADIUS_W-1:0] radius_w;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if ({21'b0, d} > 32'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(d);
    end
    return r;
  endfunction

  assign radius_w = cfg_wdata_i[RADIUS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= clamp_dim(PAD_DIM_RST);
      height_q <= clamp_dim(PAD_DIM_RST);
      lim_q    <= LIM_W'(RADIUS_RST) * LIM_W'(RADIUS_RST);
      scale_q  <= SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PAD_WIDTH:  width_q  <= clamp_dim(cfg_wdata_i[DIM_CFG_W-1:0]);
        CFG_PAD_HEIGHT: height_q <= clamp_dim(cfg_wdata_i[DIM_CFG_W-1:0]);
        CFG_RADIUS:     lim_q    <= LIM_W'(radius_w) * LIM_W'(radius_w);
        CFG_SCALE:      scale_q  <= cfg_wdata_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign width_o  = width_q;
  assign height_o = height_q;
  assign lim_o    = lim_q;
  assign scale_o  = scale_q;

endmodule

### rtl/core/wwpf_raster_pos.sv
// Column and row counters with wrapped signed offsets of the current position.
`timescale 1ns / 1ps
module wwpf_raster_pos #(
  parameter int MAX_DIM = wwpf_pkg::MAX_DIM_DEF,
  parameter int DIM_W   = $clog2(MAX_DIM + 1),
  parameter int CNT_W   = $clog2(MAX_DIM),
  parameter int OFF_W   = CNT_W + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [DIM_W-1:0]        width_i,
  input  logic [DIM_W-1:0]        height_i,
  input  logic                    accept_i,
  input  logic                    last_i,
  output logic signed [OFF_W-1:0] dx_o,
  output logic signed [OFF_W-1:0] dy_o,
  output logic                    origin_o
);

  logic [CNT_W-1:0] col_q, row_q, col_d, row_d;
  logic [CNT_W-1:0] col, row;
  logic [DIM_W-1:0] col_nx, row_nx;
  logic signed [DIM_W:0] dx_wr, dy_wr;

  // a count left beyond a smaller raster reads as zero
  assign col = (DIM_W'(col_q) >= width_i)  ? '0 : col_q;
  assign row = (DIM_W'(row_q) >= height_i) ? '0 : row_q;

  assign col_nx = DIM_W'(col) + DIM_W'(1);
  assign row_nx = DIM_W'(row) + DIM_W'(1);

  assign dx_wr = $signed({1'b0, DIM_W'(col)}) - $signed({1'b0, width_i});
  assign dy_wr = $signed({1'b0, DIM_W'(row)}) - $signed({1'b0, height_i});

  assign dx_o = ({col, 1'b0} >= (CNT_W + 1)'(width_i))  ? dx_wr[OFF_W-1:0]
                                                        : $signed({1'b0, col});
  assign dy_o = ({row, 1'b0} >= (CNT_W + 1)'(height_i)) ? dy_wr[OFF_W-1:0]
                                                        : $signed({1'b0, row});
  assign origin_o = (col == '0) && (row == '0);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (last_i) begin
        col_d = '0;
        row_d = '0;
      end else if (col_nx >= width_i) begin
        col_d = '0;
        row_d = (row_nx >= height_i) ? '0 : row_nx[CNT_W-1:0];
      end else begin
        col_d = col_nx[CNT_W-1:0];
        row_d = row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

### rtl/core/wwpf_peak_track.sv
// Input register, in-circle test and running peak, with the pending result stage.
`timescale 1ns / 1ps
module wwpf_peak_track #(
  parameter int SAMPLE_BITS = wwpf_pkg::SAMPLE_BITS_DEF,
  parameter int OFF_W       = 11
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [wwpf_pkg::LIM_W-1:0]          lim_i,
  input  wwpf_pkg::stage_ctl_t                in_ctl_i,
  output logic                                in_ready_o,
  input  logic [wwpf_pkg::SAMPLE_W-1:0]       sample_i,
  input  logic signed [OFF_W-1:0]             dx_i,
  input  logic signed [OFF_W-1:0]             dy_i,
  input  logic                                origin_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output logic signed [OFF_W-1:0]             res_x_o,
  output logic signed [OFF_W-1:0]             res_y_o,
  output logic signed [wwpf_pkg::VALUE_W-1:0] res_value_o
);
  import wwpf_pkg::*;

  localparam int SUM_W = 2 * OFF_W + 1;
  localparam int CMP_W = (SUM_W > LIM_W) ? SUM_W : LIM_W;

  logic signed [VALUE_W-1:0] value_ext;

  if (SAMPLE_BITS > SAMPLE_W) begin : g_zext
    assign value_ext = {1'b0, sample_i};
  end else begin : g_sext
    assign value_ext = {{(VALUE_W - SAMPLE_BITS){sample_i[SAMPLE_BITS-1]}},
                        sample_i[SAMPLE_BITS-1:0]};
  end

  // input register
  logic                      s1_valid_q, s1_last_q, s1_org_q;
  logic signed [VALUE_W-1:0] s1_val_q;
  logic signed [OFF_W-1:0]   s1_dx_q, s1_dy_q;

  // running peak
  logic signed [VALUE_W-1:0] best_val_q, best_val_d;
  logic signed [OFF_W-1:0]   best_x_q, best_x_d, best_y_q, best_y_d;

  // pending result
  logic                      s2_valid_q;
  logic signed [VALUE_W-1:0] s2_val_q;
  logic signed [OFF_W-1:0]   s2_x_q, s2_y_q;

  logic s2_free, s1_go, accept, in_circle;
  logic [2*OFF_W-1:0] sq_x, sq_y;
  logic [SUM_W-1:0]   rsq;

  assign s2_free    = !s2_valid_q || res_ready_i;
  assign s1_go      = s1_valid_q && (!s1_last_q || s2_free);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign accept     = in_ctl_i.valid && in_ready_o;

  assign sq_x      = $unsigned((2*OFF_W)'(s1_dx_q) * (2*OFF_W)'(s1_dx_q));
  assign sq_y      = $unsigned((2*OFF_W)'(s1_dy_q) * (2*OFF_W)'(s1_dy_q));
  assign rsq       = SUM_W'(sq_x) + SUM_W'(sq_y);
  assign in_circle = CMP_W'(rsq) < CMP_W'(lim_i);

  always_comb begin
    best_val_d = best_val_q;
    best_x_d   = best_x_q;
    best_y_d   = best_y_q;
    if (s1_go) begin
      if (s1_org_q) begin
        best_val_d = s1_val_q;
        best_x_d   = '0;
        best_y_d   = '0;
      end else if (in_circle && (s1_val_q > best_val_q)) begin
        best_val_d = s1_val_q;
        best_x_d   = s1_dx_q;
        best_y_d   = s1_dy_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      best_val_q <= '0;
      best_x_q   <= '0;
      best_y_q   <= '0;
    end else begin
      best_val_q <= best_val_d;
      best_x_q   <= best_x_d;
      best_y_q   <= best_y_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go && s1_last_q) begin
        s2_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_val_q  <= value_ext;
      s1_last_q <= in_ctl_i.last;
      s1_dx_q   <= dx_i;
      s1_dy_q   <= dy_i;
      s1_org_q  <= origin_i;
    end
    if (s1_go && s1_last_q) begin
      s2_val_q <= best_val_d;
      s2_x_q   <= best_x_d;
      s2_y_q   <= best_y_d;
    end
  end

  assign res_valid_o = s2_valid_q;
  assign res_x_o     = s2_x_q;
  assign res_y_o     = s2_y_q;
  assign res_value_o = s2_val_q;

endmodule

### rtl/core/wwpf_shift_out.sv
// Scaling of peak offsets to Q16 shifts with saturation, and the output register.
`timescale 1ns / 1ps
module wwpf_shift_out #(
  parameter int OFF_W = 11
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [wwpf_pkg::SCALE_W-1:0]        scale_i,
  input  logic                                res_valid_i,
  output logic                                res_ready_o,
  input  logic signed [OFF_W-1:0]             res_x_i,
  input  logic signed [OFF_W-1:0]             res_y_i,
  input  logic signed [wwpf_pkg::VALUE_W-1:0] res_value_i,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [wwpf_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import wwpf_pkg::*;

  localparam int PROD_W = OFF_W + SCALE_W + 1;
  localparam int SAT_W  = (PROD_W > SHIFT_W + 1) ? PROD_W : SHIFT_W + 1;
  localparam int EXT_W  = (OFF_W > OFFSET_W) ? OFF_W : OFFSET_W;
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(SHIFT_LIMIT);
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_W'(SHIFT_LIMIT);

  logic                         out_valid_q;
  logic [OUT_DATA_W-1:0]        out_data_q;
  logic signed [SCALE_W:0]      scale_s;
  logic signed [PROD_W-1:0]     prod_x, prod_y;
  logic signed [SAT_W-1:0]      wide_x, wide_y;
  logic signed [SHIFT_W-1:0]    shift_x, shift_y;
  logic signed [EXT_W-1:0]      ext_x, ext_y;
  logic                         load;

  function automatic logic signed [SHIFT_W-1:0] sat_shift(input logic signed [SAT_W-1:0] p);
    logic signed [SAT_W-1:0] r;
    if (p > SAT_HI) begin
      r = SAT_HI;
    end else if (p < SAT_LO) begin
      r = SAT_LO;
    end else begin
      r = p;
    end
    return r[SHIFT_W-1:0];
  endfunction

  assign scale_s = $signed({1'b0, scale_i});
  assign prod_x  = PROD_W'(res_x_i) * PROD_W'(scale_s);
  assign prod_y  = PROD_W'(res_y_i) * PROD_W'(scale_s);
  assign wide_x  = SAT_W'(prod_x);
  assign wide_y  = SAT_W'(prod_y);
  assign shift_x = sat_shift(wide_x);
  assign shift_y = sat_shift(wide_y);
  assign ext_x   = EXT_W'(res_x_i);
  assign ext_y   = EXT_W'(res_y_i);

  assign res_ready_o = !out_valid_q || m_axis_tready;
  assign load        = res_valid_i && res_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= {res_value_i[PEAK_W-1:0], shift_y, shift_x,
                     ext_y[OFFSET_W-1:0], ext_x[OFFSET_W-1:0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### rtl/core/wrapped_window_peak_finder.sv
// Top level of the wrapped-window correlation peak finder.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: sample; tlast: last
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: x_offset, y_offset,
//                                                    x_shift_q16, y_shift_q16, peak_value
//  cfg       in         cfg_we_i                     cfg_index_i, cfg_wdata_i
//
// One item per cycle, but for the hold on a last-marked item below. The result of a raster
// passes through the input register and peak update into the pending result stage, then
// through the offset-times-scale multiply into the output register, which drives m_axis.
// Reset clears counters, running peak and valid flags, and sets registers to defaults.
// Items keep flowing while a result waits; only a further last-marked item is held
// while both the pending result stage and the output register are full.
`timescale 1ns / 1ps
module wrapped_window_peak_finder #(
  parameter int MAX_DIM     = wwpf_pkg::MAX_DIM_DEF,
  parameter int SAMPLE_BITS = wwpf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [wwpf_pkg::SAMPLE_W-1:0]     s_axis_tdata,   // [31:0] sample
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [9:0] x_offset, [19:10] y_offset, [45:20] x_shift_q16, [71:46] y_shift_q16,
  // [103:72] peak_value
  output logic [wwpf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [wwpf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wwpf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import wwpf_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int OFF_W = CNT_W + 1;

  logic [DIM_W-1:0]          width, height;
  logic [LIM_W-1:0]          lim;
  logic [SCALE_W-1:0]        scale;
  logic signed [OFF_W-1:0]   dx, dy, res_x, res_y;
  logic                      origin, res_valid, res_ready;
  logic signed [VALUE_W-1:0] res_value;
  stage_ctl_t                in_ctl;

  assign in_ctl.valid = s_axis_tvalid;
  assign in_ctl.last  = s_axis_tlast;

  wwpf_cfg_regs #(
    .MAX_DIM (MAX_DIM),
    .DIM_W   (DIM_W)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .width_o     (width),
    .height_o    (height),
    .lim_o       (lim),
    .scale_o     (scale)
  );

  wwpf_raster_pos #(
    .MAX_DIM (MAX_DIM),
    .DIM_W   (DIM_W),
    .CNT_W   (CNT_W),
    .OFF_W   (OFF_W)
  ) u_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .width_i  (width),
    .height_i (height),
    .accept_i (s_axis_tvalid && s_axis_tready),
    .last_i   (s_axis_tlast),
    .dx_o     (dx),
    .dy_o     (dy),
    .origin_o (origin)
  );

  wwpf_peak_track #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .OFF_W       (OFF_W)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lim_i       (lim),
    .in_ctl_i    (in_ctl),
    .in_ready_o  (s_axis_tready),
    .sample_i    (s_axis_tdata),
    .dx_i        (dx),
    .dy_i        (dy),
    .origin_i    (origin),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_x_o     (res_x),
    .res_y_o     (res_y),
    .res_value_o (res_value)
  );

  wwpf_shift_out #(
    .OFF_W (OFF_W)
  ) u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .scale_i       (scale),
    .res_valid_i   (res_valid),
    .res_ready_o   (res_ready),
    .res_x_i       (res_x),
    .res_y_i       (res_y),
    .res_value_i   (res_value),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

### rtl/core/wwpf_checker.sv
// Port-level checks on the peak finder result channel, bound to the top level.
`timescale 1ns / 1ps
module wwpf_port_sva (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [wwpf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import wwpf_pkg::*;

  logic signed [SHIFT_W-1:0]  xs, ys;
  logic signed [OFFSET_W-1:0] xo, yo;

  assign xo = m_axis_tdata[OFFSET_W-1:0];
  assign yo = m_axis_tdata[XS_LSB-1:OFFSET_W];
  assign xs = m_axis_tdata[YS_LSB-1:XS_LSB];
  assign ys = m_axis_tdata[PK_LSB-1:YS_LSB];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (xs <= SHIFT_LIMIT) && (xs >= -SHIFT_LIMIT) &&
                      (ys <= SHIFT_LIMIT) && (ys >= -SHIFT_LIMIT))
    else $error("shift beyond saturation limit");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((xo != '0) || (xs == '0)) && ((yo != '0) || (ys == '0)))
    else $error("zero offset with non-zero shift");

  a_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid straight after reset");

endmodule

bind wrapped_window_peak_finder wwpf_port_sva u_wwpf_port_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### dv/wwpf_checker.sv
// Checker for the wrapped-window peak finder: tracks config, predicts peaks, compares results.
`timescale 1ns / 1ps
module wwpf_checker
  import wwpf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_tvalid_i,
  input  logic                    s_tready_i,
  input  logic [SAMPLE_W-1:0]     s_tdata_i,    // [31:0] sample
  input  logic                    s_tlast_i,
  input  logic                    m_tvalid_i,
  input  logic                    m_tready_i,
  // [9:0] x_offset, [19:10] y_offset, [45:20] x_shift_q16, [71:46] y_shift_q16,
  // [103:72] peak_value
  input  logic [OUT_DATA_W-1:0]   m_tdata_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  output int                      errors_o,
  output int                      pending_o
);

  typedef struct packed {
    logic signed [OFFSET_W-1:0] x_off;
    logic signed [OFFSET_W-1:0] y_off;
    logic signed [SHIFT_W-1:0]  x_shift;
    logic signed [SHIFT_W-1:0]  y_shift;
    logic signed [PEAK_W-1:0]   peak;
  } peak_rec_t;

  peak_rec_t peaks_due[$];

  logic [DIM_CFG_W-1:0] width_reg  = PAD_DIM_RST;
  logic [DIM_CFG_W-1:0] height_reg = PAD_DIM_RST;
  logic [RADIUS_W-1:0]  radius_reg = RADIUS_RST;
  logic [SCALE_W-1:0]   scale_reg  = SCALE_RST;

  int     col_cnt  = 0;
  int     row_cnt  = 0;
  longint best_val = 0;
  int     best_x   = 0;
  int     best_y   = 0;

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  function automatic int clamp_dim(int d);
    if (d < 1) return 1;
    if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
    return d;
  endfunction

  function automatic int wrap_pos(int pos, int dim);
    return (2 * pos >= dim) ? pos - dim : pos;
  endfunction

  function automatic logic [SHIFT_W-1:0] scaled_shift(int off, logic [SCALE_W-1:0] sc);
    longint p;
    p = longint'(off) * longint'(sc);
    if (p > SHIFT_LIMIT) p = SHIFT_LIMIT;
    if (p < -SHIFT_LIMIT) p = -SHIFT_LIMIT;
    return p[SHIFT_W-1:0];
  endfunction

  task automatic report(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors_o++;
  endtask

  task automatic match_field(string name, longint got, longint want);
    if (got != want) report($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  task automatic take_sample(logic [SAMPLE_W-1:0] raw, logic lst);
    int        w, h, col, row, dx, dy;
    longint    s, rsq, lim;
    peak_rec_t rec;
    w   = clamp_dim(int'(width_reg));
    h   = clamp_dim(int'(height_reg));
    s   = longint'($signed(raw));
    col = (col_cnt >= w) ? 0 : col_cnt;
    row = (row_cnt >= h) ? 0 : row_cnt;
    dx  = wrap_pos(col, w);
    dy  = wrap_pos(row, h);
    rsq = longint'(dx) * dx + longint'(dy) * dy;
    lim = longint'(radius_reg) * longint'(radius_reg);
    if (col == 0 && row == 0) begin
      best_val = s;
      best_x   = 0;
      best_y   = 0;
    end else if (rsq < lim && s > best_val) begin
      best_val = s;
      best_x   = dx;
      best_y   = dy;
    end
    if (col + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
      row_cnt = row;
    end
    if (lst) begin
      rec.x_off   = best_x[OFFSET_W-1:0];
      rec.y_off   = best_y[OFFSET_W-1:0];
      rec.x_shift = scaled_shift(best_x, scale_reg);
      rec.y_shift = scaled_shift(best_y, scale_reg);
      rec.peak    = best_val[PEAK_W-1:0];
      peaks_due.push_back(rec);
      col_cnt = 0;
      row_cnt = 0;
    end
  endtask

  task automatic check_result(logic [OUT_DATA_W-1:0] d);
    peak_rec_t want;
    if (peaks_due.size() == 0) begin
      report("result with nothing expected");
    end else begin
      want = peaks_due.pop_front();
      match_field("x_offset", $signed(d[OFFSET_W-1:0]), want.x_off);
      match_field("y_offset", $signed(d[2*OFFSET_W-1:OFFSET_W]), want.y_off);
      match_field("x_shift_q16", $signed(d[XS_LSB +: SHIFT_W]), want.x_shift);
      match_field("y_shift_q16", $signed(d[YS_LSB +: SHIFT_W]), want.y_shift);
      match_field("peak_value", $signed(d[PK_LSB +: PEAK_W]), want.peak);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = PAD_DIM_RST;
      height_reg = PAD_DIM_RST;
      radius_reg = RADIUS_RST;
      scale_reg  = SCALE_RST;
      col_cnt    = 0;
      row_cnt    = 0;
      best_val   = 0;
      best_x     = 0;
      best_y     = 0;
      peaks_due.delete();
      pending_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_PAD_WIDTH:  width_reg  = cfg_wdata_i[DIM_CFG_W-1:0];
          CFG_PAD_HEIGHT: height_reg = cfg_wdata_i[DIM_CFG_W-1:0];
          CFG_RADIUS:     radius_reg = cfg_wdata_i[RADIUS_W-1:0];
          CFG_SCALE:      scale_reg  = cfg_wdata_i[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) check_result(m_tdata_i);
      if (s_tvalid_i && s_tready_i) take_sample(s_tdata_i, s_tlast_i);
      pending_o = peaks_due.size();
    end
  end

endmodule

### dv/testbench.sv
// Top of the peak finder testbench: clock, reset, sample stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps
module testbench;
  import wwpf_pkg::*;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = CFG_PAD_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  int fails;
  int pending;
  int items_sent   = 0;
  int results_due  = 0;
  bit tx_steady    = 1'b0;
  int hold_reqs    = 0;
  int hold_seen    = 0;

  always #1 clk_i = ~clk_i;

  wrapped_window_peak_finder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  wwpf_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .errors_o    (fails),
    .pending_o   (pending)
  );

  // result side: random stalls, one quiet stretch, long hold-off on request
  initial begin
    int cyc;
    int hold_left;
    cyc       = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else if (cyc >= 300 && cyc < 1100) begin
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = ($urandom_range(0, 99) >= 18);
      end
    end
  end

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int k;
    k = $urandom_range(0, 9);
    if (k < 4) return $urandom();
    if (k < 7) return SAMPLE_W'($urandom_range(0, 15) - 8);
    if (k < 8) return 32'h7FFF_FFFF;
    if (k < 9) return 32'h8000_0000;
    return $urandom_range(0, 1000);
  endfunction

  task automatic push_sample(logic [SAMPLE_W-1:0] value, bit lst);
    while (!tx_steady && $urandom_range(0, 99) < 18) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = value;
    s_axis_tlast  = lst;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
    if (lst) results_due++;
  endtask

  task automatic set_reg(cfg_idx_e idx, int value);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = CFG_DATA_W'(value);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // wait for the pipeline to drain before touching registers
  task automatic configure(int w, int h, int r, int sc);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    set_reg(CFG_PAD_WIDTH, w);
    set_reg(CFG_PAD_HEIGHT, h);
    set_reg(CFG_RADIUS, r);
    set_reg(CFG_SCALE, sc);
  endtask

  function automatic int pick_dim();
    int k;
    k = $urandom_range(0, 19);
    if (k < 14) return $urandom_range(1, 8);
    if (k < 16) return 0;
    if (k < 18) return $urandom_range(1025, 2047);
    return $urandom_range(9, 40);
  endfunction

  initial begin
    int phase, k, n, w_val, h_val, r_val, sc_val, area, nf;
    logic [SAMPLE_W-1:0] grid_3x3 [9];
    grid_3x3 = '{32'hFFFF_FFF6, 32'd3, 32'd5, 32'd5, 32'h8000_0000, 32'd7, 32'd0,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset defaults: single-item rasters, then a short run inside the circle
    push_sample(32'h8000_0000, 1'b1);
    push_sample(32'h7FFF_FFFF, 1'b1);
    push_sample(32'd0, 1'b0);
    push_sample(32'd5, 1'b0);
    push_sample(32'd9, 1'b1);

    // 3x3 raster, every offset in the circle, ties must not replace
    configure(3, 3, 2, 65536);
    for (int i = 0; i < 9; i++) push_sample(grid_3x3[i], i == 8);

    // zero radius: the origin sample wins
    configure(2, 2, 0, 65536);
    push_sample(32'd1, 1'b0);
    push_sample(32'd100, 1'b0);
    push_sample(32'd200, 1'b0);
    push_sample(32'd300, 1'b1);

    phase = 0;
    while (items_sent < 1100 || results_due < 40) begin
      phase++;
      tx_steady = (phase >= 4 && phase < 6);
      case (phase)
        3: begin
          // one-sample rasters against a stalled receiver
          configure(1, 0, $urandom_range(0, 1023), $urandom_range(0, 131071));
          hold_reqs <= hold_reqs + 1;
          repeat (30) push_sample(pick_sample(), 1'b1);
          s_axis_tvalid = 1'b0;
          while (pending != 0) @(negedge clk_i);
        end
        5: begin
          // widest row, peak at the most negative column offset, shift saturates
          configure(1024, 1, 1023, 131071);
          for (int i = 0; i < 513; i++)
            push_sample((i == 512) ? 32'h7FFF_FFFF : $urandom_range(0, 1000), i == 512);
        end
        8: begin
          // tallest column via clamped height, positive row shift saturates
          configure(1, 1500, 1023, 131071);
          for (int i = 0; i < 257; i++)
            push_sample((i == 256) ? 32'h7FFF_FFFF : $urandom_range(0, 1000), i == 256);
        end
        default: begin
          w_val = pick_dim();
          h_val = pick_dim();
          k = $urandom_range(0, 19);
          if (k < 10)      r_val = $urandom_range(0, 6);
          else if (k < 14) r_val = $urandom_range(7, 40);
          else if (k < 16) r_val = 1023;
          else             r_val = $urandom_range(0, 131071);
          k = $urandom_range(0, 19);
          if (k < 14)      sc_val = $urandom_range(0, 131071);
          else if (k < 16) sc_val = 0;
          else if (k < 18) sc_val = 65536;
          else             sc_val = 131071;
          configure(w_val, h_val, r_val, sc_val);
          area = ((w_val < 1) ? 1 : (w_val > MAX_DIM_DEF) ? MAX_DIM_DEF : w_val) *
                 ((h_val < 1) ? 1 : (h_val > MAX_DIM_DEF) ? MAX_DIM_DEF : h_val);
          nf = $urandom_range(1, 4);
          repeat (nf) begin
            if ($urandom_range(0, 9) == 0)
              repeat ($urandom_range(1, 5)) push_sample(pick_sample(), 1'b0);
            k = $urandom_range(0, 9);
            if (area > 64)   n = $urandom_range(1, 48);
            else if (k < 8)  n = area;
            else if (k < 9)  n = area + $urandom_range(1, area);
            else             n = $urandom_range(1, area);
            for (int i = 0; i < n; i++) push_sample(pick_sample(), i == n - 1);
          end
        end
      endcase
    end

    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
